### hw/rtl/emasm_pkg.sv
// Shared constants and types for the temperature smoother with extremes and redraw logic.
package emasm_pkg;

  localparam int GAIN_BITS      = 9;
  localparam int THRESH_BITS    = 15;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 1;
  localparam int GAIN_SHIFT     = 8;

  localparam logic [GAIN_BITS-1:0]      GAIN_ONE     = 9'd256;
  localparam logic [GAIN_BITS-1:0]      GAIN_RESET   = 9'd51;
  localparam logic [THRESH_BITS-1:0]    THRESH_RESET = 15'd10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'd1;

  // Control for the item being processed this cycle.
  typedef struct packed {
    logic fire;        // item leaves the input register this cycle
    logic sample_ok;   // present and without error
    logic redraw_req;  // caller asks for a redraw
  } step_ctrl_t;

endpackage

### hw/rtl/ema_smoother_minmax_redraw_core.sv
// Top level: input register, configuration registers, processing and result register.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    channel_valid, channel_error, sample, force_redraw
//   result    result_valid / result_stall redraw_value, redraw_dashes, smoothed, highest,
//                                        lowest, extremes_known
//   config    cfg_write                  cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; an accepted item passes
// through the input register and then the result register.
// The filter multiply-add, extremes and redraw compares are combinational
// between the input register and the result register.
// Reset loads default gain and threshold and clears other state: first sample loads the
// filter and a redraw is pending. A stalled result holds the item in the input register;
// stall reaches item_stall only when both registers are full.
module ema_smoother_minmax_redraw_core #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  output logic                                    item_stall,
  input  logic                                    channel_valid,
  input  logic                                    channel_error,
  input  logic signed [SAMPLE_BITS-1:0]           sample,
  input  logic                                    force_redraw,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic                                    redraw_value,
  output logic                                    redraw_dashes,
  output logic signed [SAMPLE_BITS-1:0]           smoothed,
  output logic signed [SAMPLE_BITS-1:0]           highest,
  output logic signed [SAMPLE_BITS-1:0]           lowest,
  output logic                                    extremes_known,
  input  logic                                    cfg_write,
  input  logic [emasm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [emasm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import emasm_pkg::*;

  logic [GAIN_BITS-1:0]          gain;
  logic [THRESH_BITS-1:0]        threshold;

  logic                          q_valid;
  logic                          q_ok;
  logic                          q_force;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic                          accept;
  step_ctrl_t                    ctrl;

  logic signed [SAMPLE_BITS-1:0] cur;
  logic                          loaded;
  logic                          rv_c;
  logic                          rd_c;
  logic signed [SAMPLE_BITS-1:0] hi_c;
  logic signed [SAMPLE_BITS-1:0] lo_c;
  logic                          known_c;

  assign ctrl.fire       = q_valid && (!result_valid || !result_stall);
  assign ctrl.sample_ok  = q_ok;
  assign ctrl.redraw_req = q_force;

  assign item_stall = q_valid && !ctrl.fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RESET;
      threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN:      gain      <= cfg_data[GAIN_BITS-1:0];
        REG_THRESHOLD: threshold <= cfg_data[THRESH_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // input register: take a new beat when empty or whenever the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (ctrl.fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_ok     <= channel_valid && !channel_error;
      q_force  <= force_redraw;
      q_sample <= sample;
    end
  end

  emasm_filter #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (q_sample),
    .gain   (gain),
    .cur    (cur),
    .loaded (loaded)
  );

  emasm_track #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .loaded         (loaded),
    .cur            (cur),
    .threshold      (threshold),
    .redraw_value   (rv_c),
    .redraw_dashes  (rd_c),
    .highest        (hi_c),
    .lowest         (lo_c),
    .extremes_known (known_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      redraw_value   <= rv_c;
      redraw_dashes  <= rd_c;
      smoothed       <= cur;
      highest        <= hi_c;
      lowest         <= lo_c;
      extremes_known <= known_c;
    end
  end

endmodule

### hw/rtl/emasm_filter.sv
// EMA accumulator; first good sample after reset or a bad sample loads it directly.
module emasm_filter #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  emasm_pkg::step_ctrl_t               ctrl,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic [emasm_pkg::GAIN_BITS-1:0]     gain,
  output logic signed [SAMPLE_BITS-1:0]       cur,
  output logic                                loaded
);
  import emasm_pkg::*;

  localparam int AW = SAMPLE_BITS + FRACTION_BITS;
  localparam int PW = AW + 1 + GAIN_BITS + 1;

  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  acc_next;
  logic                  first_pending;
  logic [GAIN_BITS-1:0]  gain_sat;
  logic signed [AW-1:0]  sample_fx;
  logic signed [AW:0]    diff;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  delta;

  assign gain_sat  = (gain > GAIN_ONE) ? GAIN_ONE : gain;
  assign sample_fx = {sample, {FRACTION_BITS{1'b0}}};
  // acc + floor(g * (s - acc) / 256) equals the weighted mix of sample and acc
  assign diff      = {sample_fx[AW-1], sample_fx} - {acc[AW-1], acc};
  assign prod      = $signed({1'b0, gain_sat}) * diff;
  assign delta     = prod >>> GAIN_SHIFT;

  always_comb begin
    if (first_pending) begin
      acc_next = sample_fx;
    end else begin
      acc_next = acc + delta[AW-1:0];
    end
  end

  assign loaded = ctrl.sample_ok && first_pending;
  assign cur    = ctrl.sample_ok ? acc_next[AW-1:FRACTION_BITS] : acc[AW-1:FRACTION_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      first_pending <= 1'b1;
    end else if (ctrl.fire) begin
      if (ctrl.sample_ok) begin
        acc           <= acc_next;
        first_pending <= 1'b0;
      end else begin
        first_pending <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/emasm_track.sv
// Running extremes, last-shown values and the redraw decision.
module emasm_track #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  emasm_pkg::step_ctrl_t               ctrl,
  input  logic                                loaded,
  input  logic signed [SAMPLE_BITS-1:0]       cur,
  input  logic [emasm_pkg::THRESH_BITS-1:0]   threshold,
  output logic                                redraw_value,
  output logic                                redraw_dashes,
  output logic signed [SAMPLE_BITS-1:0]       highest,
  output logic signed [SAMPLE_BITS-1:0]       lowest,
  output logic                                extremes_known
);
  import emasm_pkg::*;

  localparam int DW = SAMPLE_BITS + 1;
  localparam int CW = (DW > THRESH_BITS) ? DW : THRESH_BITS;

  logic signed [SAMPLE_BITS-1:0] peak_value;
  logic signed [SAMPLE_BITS-1:0] trough_value;
  logic signed [SAMPLE_BITS-1:0] max_next;
  logic signed [SAMPLE_BITS-1:0] min_next;
  logic                          have_extremes;
  logic                          have_next;
  logic                          redraw_pending;
  logic                          pend;
  logic                          shown_valid;
  logic signed [SAMPLE_BITS-1:0] shown_value;
  logic signed [SAMPLE_BITS-1:0] shown_max;
  logic signed [SAMPLE_BITS-1:0] shown_min;
  logic                          moved_any;

  function automatic logic moved(input logic signed [SAMPLE_BITS-1:0] a,
                                 input logic signed [SAMPLE_BITS-1:0] b,
                                 input logic [THRESH_BITS-1:0] thr);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        mag;
    d   = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    return CW'(mag) >= CW'(thr);
  endfunction

  assign max_next  = (!have_extremes || cur > peak_value) ? cur : peak_value;
  assign min_next  = (!have_extremes || cur < trough_value) ? cur : trough_value;
  assign have_next = have_extremes || ctrl.sample_ok;

  // a direct filter load always asks for a redraw
  assign pend = redraw_pending || ctrl.redraw_req || loaded;

  assign moved_any = moved(cur, shown_value, threshold) || moved(max_next, shown_max, threshold)
                  || moved(min_next, shown_min, threshold);

  assign redraw_value  = ctrl.sample_ok && (!shown_valid || moved_any || pend);
  assign redraw_dashes = !ctrl.sample_ok && (pend || shown_valid);

  always_comb begin
    if (ctrl.sample_ok) begin
      highest = have_next ? max_next : '0;
      lowest  = have_next ? min_next : '0;
    end else begin
      highest = have_extremes ? peak_value : '0;
      lowest  = have_extremes ? trough_value : '0;
    end
  end
  assign extremes_known = have_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value     <= '0;
      trough_value   <= '0;
      have_extremes  <= 1'b0;
      redraw_pending <= 1'b1;
      shown_valid    <= 1'b0;
      shown_value    <= '0;
      shown_max      <= '0;
      shown_min      <= '0;
    end else if (ctrl.fire) begin
      have_extremes  <= have_next;
      redraw_pending <= (redraw_value || redraw_dashes) ? 1'b0 : pend;
      if (ctrl.sample_ok) begin
        peak_value   <= max_next;
        trough_value <= min_next;
      end
      if (redraw_value) begin
        shown_valid <= 1'b1;
        shown_value <= cur;
        shown_max   <= max_next;
        shown_min   <= min_next;
      end else if (redraw_dashes) begin
        shown_valid <= 1'b0;
      end
    end
  end

endmodule

### verif/smoother_checker.sv
// Checker for the temperature smoother: predicts each result beat and compares it.
module smoother_checker #(
  parameter int SAMPLE_W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  logic                                 channel_valid,
  input  logic                                 channel_error,
  input  logic signed [SAMPLE_W-1:0]           sample,
  input  logic                                 force_redraw,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic                                 redraw_value,
  input  logic                                 redraw_dashes,
  input  logic signed [SAMPLE_W-1:0]           smoothed,
  input  logic signed [SAMPLE_W-1:0]           highest,
  input  logic signed [SAMPLE_W-1:0]           lowest,
  input  logic                                 extremes_known,
  input  logic                                 cfg_write,
  input  logic [emasm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [emasm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                   mismatches,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import emasm_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int ACC_W     = SAMPLE_W + FRAC_BITS;

  typedef struct packed {
    logic                       redraw_value;
    logic                       redraw_dashes;
    logic signed [SAMPLE_W-1:0] smoothed;
    logic signed [SAMPLE_W-1:0] highest;
    logic signed [SAMPLE_W-1:0] lowest;
    logic                       extremes_known;
  } display_t;

  display_t display_q[$];
  int       errs = 0;

  // Shadow of the block's registers and filter state.
  logic [GAIN_BITS-1:0]       gain;
  logic [THRESH_BITS-1:0]     thresh;
  logic signed [ACC_W-1:0]    acc;
  logic                       load_next;
  logic                       redraw_owed;
  logic                       have_ext;
  logic signed [SAMPLE_W-1:0] max_v;
  logic signed [SAMPLE_W-1:0] min_v;
  logic                       shown_ok;
  logic signed [SAMPLE_W-1:0] shown_v;
  logic signed [SAMPLE_W-1:0] shown_hi;
  logic signed [SAMPLE_W-1:0] shown_lo;

  function automatic logic moved(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b);
    int diff;
    diff = int'(a) - int'(b);
    if (diff < 0) diff = -diff;
    return diff >= int'(thresh);
  endfunction

  function automatic display_t predict_display(logic cv, logic ce,
                                               logic signed [SAMPLE_W-1:0] s, logic fr);
    display_t                   d;
    longint                     g;
    longint                     mix;
    logic signed [SAMPLE_W-1:0] cur;
    d = '0;
    if (fr) redraw_owed = 1'b1;
    if (cv && !ce) begin
      if (load_next) begin
        acc = ACC_W'(longint'(s) <<< FRAC_BITS);
        load_next = 1'b0;
        redraw_owed = 1'b1;
      end else begin
        // saturate the gain to 1.0
        g = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
        mix = ((g * longint'(s)) <<< FRAC_BITS) + (longint'(GAIN_ONE) - g) * longint'(acc);
        acc = ACC_W'(mix >>> GAIN_SHIFT);
      end
      cur = acc[ACC_W-1:FRAC_BITS];
      if (!have_ext || cur > max_v) max_v = cur;
      if (!have_ext || cur < min_v) min_v = cur;
      have_ext = 1'b1;
      if (!shown_ok || moved(cur, shown_v) || moved(max_v, shown_hi) ||
          moved(min_v, shown_lo) || redraw_owed) begin
        d.redraw_value = 1'b1;
        shown_v = cur;
        shown_hi = max_v;
        shown_lo = min_v;
        shown_ok = 1'b1;
        redraw_owed = 1'b0;
      end
    end else begin
      cur = acc[ACC_W-1:FRAC_BITS];
      if (redraw_owed || shown_ok) begin
        d.redraw_dashes = 1'b1;
        shown_ok = 1'b0;
        redraw_owed = 1'b0;
      end
      load_next = 1'b1;
    end
    d.smoothed = cur;
    d.highest = have_ext ? max_v : '0;
    d.lowest = have_ext ? min_v : '0;
    d.extremes_known = have_ext;
    return d;
  endfunction

  task automatic check_field(input string what, input logic signed [SAMPLE_W-1:0] want,
                             input logic signed [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    display_t want;
    if (rst) begin
      gain = GAIN_RESET;
      thresh = THRESH_RESET;
      acc = '0;
      load_next = 1'b1;
      redraw_owed = 1'b1;
      have_ext = 1'b0;
      max_v = '0;
      min_v = '0;
      shown_ok = 1'b0;
      shown_v = '0;
      shown_hi = '0;
      shown_lo = '0;
      display_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_GAIN) gain = cfg_data[GAIN_BITS-1:0];
        else if (cfg_index == REG_THRESHOLD) thresh = cfg_data[THRESH_BITS-1:0];
      end
      // compare before queueing so a spurious beat never meets its own prediction
      if (result_valid && !result_stall) begin
        if (display_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errs++;
        end else begin
          want = display_q.pop_front();
          check_field("redraw_value", want.redraw_value, redraw_value);
          check_field("redraw_dashes", want.redraw_dashes, redraw_dashes);
          check_field("smoothed", want.smoothed, smoothed);
          check_field("highest", want.highest, highest);
          check_field("lowest", want.lowest, lowest);
          check_field("extremes_known", want.extremes_known, extremes_known);
        end
      end
      if (item_valid && !item_stall)
        display_q.push_back(predict_display(channel_valid, channel_error, sample,
                                            force_redraw));
    end
    outstanding <= display_q.size();
    mismatches <= errs;
  end

endmodule

### verif/testbench.sv
// Top of the smoother testbench: clock, reset, stimulus, register writes and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import emasm_pkg::*;

  localparam int SAMPLE_W    = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BUSY_PCT    = 28;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        item_valid;
  logic                        item_stall;
  logic                        channel_valid;
  logic                        channel_error;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        force_redraw;
  logic                        result_valid;
  logic                        result_stall;
  logic                        redraw_value;
  logic                        redraw_dashes;
  logic signed [SAMPLE_W-1:0]  smoothed;
  logic signed [SAMPLE_W-1:0]  highest;
  logic signed [SAMPLE_W-1:0]  lowest;
  logic                        extremes_known;
  logic                        cfg_write;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_data;
  int                          mismatches;
  int                          outstanding;
  int                          idle_pct = BUSY_PCT;
  int                          cycles = 0;
  int                          temp = 2150;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ema_smoother_minmax_redraw_core #(.SAMPLE_BITS(SAMPLE_W)) u_top (.*);

  smoother_checker #(.SAMPLE_W(SAMPLE_W)) u_checker (.*);

  always @(posedge clk) result_stall <= ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one beat after a random gap; item_valid stays high for the next call.
  task automatic send_item(input logic cv, input logic ce, input logic signed [SAMPLE_W-1:0] s,
                           input logic fr);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    channel_valid <= cv;
    channel_error <= ce;
    sample <= s;
    force_redraw <= fr;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [GAIN_BITS-1:0] g, input logic [THRESH_BITS-1:0] t);
    cfg_write <= 1'b1;
    cfg_index <= REG_GAIN;
    // upper data bits are beyond the gain register and must be dropped
    cfg_data <= {(CFG_DATA_BITS - GAIN_BITS)'($urandom), g};
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_data <= t;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly a drifting temperature; some full-range jumps and sensor dropouts.
  task automatic random_item();
    int                         pick;
    logic                       cv;
    logic                       ce;
    logic                       fr;
    logic signed [SAMPLE_W-1:0] s;
    pick = $urandom_range(99);
    fr = ($urandom_range(19) == 0);
    cv = 1'b1;
    ce = 1'b0;
    if (pick < 10) begin
      cv = 1'($urandom_range(1));
      ce = cv ? 1'b1 : 1'($urandom_range(1));
      s = SAMPLE_W'($urandom);
    end else if (pick < 20) begin
      s = SAMPLE_W'($urandom);
    end else begin
      if ($urandom_range(49) == 0) temp = int'($urandom_range(65535)) - 32768;
      temp += int'($urandom_range(80)) - 40;
      if (temp > 32767) temp = 32767;
      if (temp < -32768) temp = -32768;
      s = SAMPLE_W'(temp);
    end
    send_item(cv, ce, s, fr);
  endtask

  initial begin
    int gains[8];
    int thrs[8];
    rst <= 1'b1;
    item_valid <= 1'b0;
    channel_valid <= 1'b0;
    channel_error <= 1'b0;
    sample <= '0;
    force_redraw <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= REG_GAIN;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: dashes owed at start, first-sample load, error and force cases
    send_item(1'b0, 1'b0, 16'sd0, 1'b0);
    send_item(1'b0, 1'b0, 16'sd0, 1'b0);
    send_item(1'b1, 1'b0, 16'sh7fff, 1'b0);
    send_item(1'b1, 1'b0, 16'sh7fff, 1'b0);
    send_item(1'b1, 1'b0, -16'sh8000, 1'b0);
    send_item(1'b1, 1'b1, 16'sd1234, 1'b0);
    send_item(1'b1, 1'b0, 16'sd0, 1'b0);
    send_item(1'b1, 1'b0, 16'sd5, 1'b0);
    send_item(1'b1, 1'b0, 16'sd5, 1'b1);
    send_item(1'b0, 1'b1, 16'sd77, 1'b1);
    send_item(1'b0, 1'b1, 16'sd77, 1'b1);
    send_item(1'b1, 1'b0, -16'sd1, 1'b0);
    send_item(1'b1, 1'b0, -16'sh8000, 1'b0);
    send_item(1'b1, 1'b0, 16'sh7fff, 1'b0);
    drain();

    // full gain with zero threshold: every valid beat redraws
    set_config(GAIN_ONE, '0);
    send_item(1'b1, 1'b0, 16'sd100, 1'b0);
    send_item(1'b1, 1'b0, -16'sd100, 1'b0);
    send_item(1'b1, 1'b0, 16'sh7fff, 1'b0);
    send_item(1'b1, 1'b0, -16'sh8000, 1'b0);
    drain();

    // zero gain holds the filter; widest threshold
    set_config('0, '1);
    send_item(1'b1, 1'b0, 16'sd1000, 1'b0);
    send_item(1'b1, 1'b0, 16'sh7fff, 1'b0);
    send_item(1'b0, 1'b0, 16'sd0, 1'b0);
    send_item(1'b1, 1'b0, 16'sd77, 1'b0);
    drain();

    // gain above one saturates
    set_config('1, 15'd10);
    send_item(1'b1, 1'b0, 16'sd300, 1'b0);
    send_item(1'b1, 1'b0, -16'sd300, 1'b0);
    drain();

    gains = '{51, 256, 0, 511, 257, 128, 1, 0};
    thrs  = '{10, 0, 32767, 5, 100, 1, 20, 0};
    gains[7] = $urandom_range(511);
    thrs[7] = $urandom_range(200);
    for (int p = 0; p < 8; p++) begin
      set_config(GAIN_BITS'(gains[p]), THRESH_BITS'(thrs[p]));
      idle_pct = (p == 5) ? 0 : BUSY_PCT;
      for (int i = 0; i < 106; i++) random_item();
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
